// ===== hdl/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// rau_pkg
// shared types and codes for the rational arithmetic unit
// ----------------------------------------------------------------------------
package rau_pkg;

  // operation codes
  localparam logic [2:0] KIND_ADD = 3'd0;
  localparam logic [2:0] KIND_SUB = 3'd1;
  localparam logic [2:0] KIND_MUL = 3'd2;
  localparam logic [2:0] KIND_DIV = 3'd3;
  localparam logic [2:0] KIND_EQ  = 3'd4;
  localparam logic [2:0] KIND_GT  = 3'd5;
  localparam logic [2:0] KIND_LT  = 3'd6;
  localparam logic [2:0] KIND_NOP = 3'd7;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [15:0] a_num;
    logic [14:0]        a_den;
    logic signed [15:0] b_num;
    logic [14:0]        b_den;
  } rau_in_t;

  typedef struct packed {
    logic signed [31:0] res_num;
    logic [29:0]        res_den;
    logic               cmp_true;
    logic               div_error;
  } rau_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_FORM,
    ST_SIGN,
    ST_MAG,
    ST_GCD,
    ST_SHIFT,
    ST_DIVN,
    ST_DIVD,
    ST_FIN,
    ST_DONE
  } rau_state_t;

  // sequencer to datapath
  typedef struct packed {
    rau_state_t st;
    logic       load;
    logic       div_last;
  } rau_ctl_t;

  // datapath to sequencer
  typedef struct packed {
    logic need_p2;
    logic is_cmp;
    logic is_nop;
    logic d_zero;
    logic gcd_done;
    logic k_zero;
  } rau_stat_t;

endpackage

// ===== hdl/rau_alu.sv =====
// ----------------------------------------------------------------------------
// rau_alu
// shared add / subtract unit
// ----------------------------------------------------------------------------
module rau_alu #(
  parameter int WIDTH = 33
) (
  input  logic [WIDTH-1:0] a,
  input  logic [WIDTH-1:0] b,
  input  logic             sub,
  output logic [WIDTH-1:0] sum
);

  assign sum = a + (b ^ {WIDTH{sub}}) + WIDTH'(sub);

endmodule

// ===== hdl/rau_mul.sv =====
// ----------------------------------------------------------------------------
// rau_mul
// signed multiplier for the cross products
// ----------------------------------------------------------------------------
module rau_mul #(
  parameter int WIDTH = 16
) (
  input  logic signed [WIDTH-1:0]   a,
  input  logic signed [WIDTH-1:0]   b,
  output logic signed [2*WIDTH-1:0] p
);

  assign p = a * b;

endmodule

// ===== hdl/rau_ctrl.sv =====
// ----------------------------------------------------------------------------
// rau_ctrl
// sequencer for the rational arithmetic unit
// ----------------------------------------------------------------------------
module rau_ctrl #(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  rau_pkg::rau_stat_t stat,
  output rau_pkg::rau_ctl_t  ctl,
  output logic              busy,
  output logic              out_valid
);
  import rau_pkg::*;

  localparam int STEPS = 2 * OPERAND_WIDTH;
  localparam int CW    = $clog2(STEPS);

  rau_state_t    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          last;

  assign last = (cnt_r == CW'(STEPS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (start) state_nxt = ST_MUL0;
      ST_MUL0:  state_nxt = stat.is_nop ? ST_DONE : ST_MUL1;
      ST_MUL1:  state_nxt = stat.need_p2 ? ST_MUL2 : ST_FORM;
      ST_MUL2:  state_nxt = ST_FORM;
      ST_FORM:  state_nxt = stat.is_cmp ? ST_DONE : ST_SIGN;
      ST_SIGN:  state_nxt = stat.d_zero ? ST_DONE : ST_MAG;
      ST_MAG:   state_nxt = ST_GCD;
      ST_GCD:   if (stat.gcd_done) state_nxt = ST_SHIFT;
      ST_SHIFT: if (stat.k_zero) state_nxt = ST_DIVN;
      ST_DIVN:  if (last) state_nxt = ST_DIVD;
      ST_DIVD:  if (last) state_nxt = ST_FIN;
      ST_FIN:   state_nxt = ST_DONE;
      ST_DONE:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // division step counter
  always_comb begin
    cnt_nxt = '0;
    if ((state_r == ST_DIVN || state_r == ST_DIVD) && !last) begin
      cnt_nxt = cnt_r + CW'(1);
    end
  end

  // outputs
  always_comb begin
    ctl.st       = state_r;
    ctl.load     = (state_r == ST_IDLE) && start;
    ctl.div_last = last;
    busy         = (state_r != ST_IDLE);
    out_valid    = (state_r == ST_DONE);
  end

endmodule

// ===== hdl/rational_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// fraction add, subtract, multiply, divide and compare with gcd reduction
// ----------------------------------------------------------------------------
// One command at a time. A command transfers on a rising edge with start high
// and busy low; busy stays high until the result has been shown. The result
// appears on out_res for exactly one cycle with out_valid high and the
// receiver cannot stall it, so it must take it then. Compares run the cross
// products and one subtract (MUL0, MUL1, FORM). Multiply and divide run two
// cross products, add and subtract a third; then come the sign and magnitude
// steps, the binary gcd loop, one restore shift per common factor of two, two
// long divisions of 2*W steps each and a final step, W being OPERAND_WIDTH.
// The gcd loop runs one shift, one subtract or one swap a cycle and is data
// dependent. All add, subtract and compare work goes through one shared
// adder; one multiplier forms the two or three cross products in turn. A zero
// formed denominator ends early with div_error set. Unused kind code 7
// returns an all zero result.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit #(
  parameter int OPERAND_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  rau_pkg::rau_in_t  in_cmd,
  output logic              out_valid,
  output rau_pkg::rau_out_t out_res
);
  import rau_pkg::*;

  localparam int W  = OPERAND_WIDTH;
  localparam int PW = 2 * W;          // product / magnitude width
  localparam int AW = PW + 1;         // shared adder width
  localparam int KW = $clog2(PW);     // common power of two count

  rau_ctl_t  ctl;
  rau_stat_t stat;

  // operand registers, numerators sign carrying, denominators unsigned
  logic [2:0]          kind_r, kind_nxt;
  logic signed [W-1:0] an_r, an_nxt, bn_r, bn_nxt;
  logic [W-2:0]        ad_r, ad_nxt, bd_r, bd_nxt;

  // cross products and formed fraction
  logic signed [PW-1:0] p0_r, p0_nxt, p1_r, p1_nxt, p2_r, p2_nxt;
  logic signed [PW-1:0] n_r, n_nxt, d_r, d_nxt;
  logic                 neg_r, neg_nxt;

  // gcd and division state
  logic [PW-1:0] mag_r, mag_nxt;
  logic [PW-1:0] gx_r, gx_nxt, gy_r, gy_nxt, g_r, g_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic [PW-1:0] q_r, q_nxt, rem_r, rem_nxt;
  logic [PW-1:0] nq_r, nq_nxt, dq_r, dq_nxt;
  rau_out_t      res_r, res_nxt;

  // shared units
  logic signed [W-1:0]  mul_a, mul_b;
  logic signed [PW-1:0] mul_p;
  logic [AW-1:0]        alu_a, alu_b, alu_sum;
  logic                 alu_sub;

  // helpers
  logic          gx_zero, gy_zero, take;
  logic [PW-1:0] mag_v, q_step;
  logic [AW-1:0] fin_val;

  rau_mul #(.WIDTH(W)) u_mul (
    .a (mul_a),
    .b (mul_b),
    .p (mul_p)
  );

  rau_alu #(.WIDTH(AW)) u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .sum (alu_sum)
  );

  rau_ctrl #(.OPERAND_WIDTH(W)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .ctl       (ctl),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // status back to the sequencer
  assign gx_zero       = (gx_r == '0);
  assign gy_zero       = (gy_r == '0);
  assign stat.need_p2  = (kind_r inside {KIND_ADD, KIND_SUB});
  assign stat.is_cmp   = (kind_r inside {KIND_EQ, KIND_GT, KIND_LT});
  assign stat.is_nop   = (kind_r == KIND_NOP);
  assign stat.d_zero   = (d_r == '0);
  assign stat.gcd_done = gx_zero || gy_zero;
  assign stat.k_zero   = (k_r == '0);

  assign out_res = res_r;

  // multiplier operand select, one cross product per state
  always_comb begin
    mul_a = an_r;
    mul_b = signed'({1'b0, bd_r});
    case (ctl.st)
      ST_MUL0: begin
        mul_a = an_r;
        mul_b = (kind_r == KIND_MUL) ? bn_r : signed'({1'b0, bd_r});
      end
      ST_MUL1: begin
        mul_a = signed'({1'b0, ad_r});
        mul_b = (kind_r == KIND_MUL) ? signed'({1'b0, bd_r}) : bn_r;
      end
      ST_MUL2: begin
        mul_a = signed'({1'b0, ad_r});
        mul_b = signed'({1'b0, bd_r});
      end
      default: begin
        mul_a = an_r;
        mul_b = signed'({1'b0, bd_r});
      end
    endcase
  end

  // shared adder operand select
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (ctl.st)
      ST_FORM: begin
        // sum or difference of cross products; compares subtract too
        alu_a   = AW'(p0_r);
        alu_b   = AW'(p1_r);
        alu_sub = (kind_r != KIND_ADD);
      end
      ST_SIGN: begin
        alu_b   = AW'(d_r);
        alu_sub = 1'b1;
      end
      ST_MAG: begin
        alu_b   = AW'(n_r);
        alu_sub = 1'b1;
      end
      ST_GCD: begin
        alu_a   = {1'b0, gx_r};
        alu_b   = {1'b0, gy_r};
        alu_sub = 1'b1;
      end
      ST_DIVN, ST_DIVD: begin
        // restoring division trial subtract
        alu_a   = {rem_r, q_r[PW-1]};
        alu_b   = {1'b0, g_r};
        alu_sub = 1'b1;
      end
      ST_FIN: begin
        alu_b   = {1'b0, nq_r};
        alu_sub = 1'b1;
      end
      default: begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
      end
    endcase
  end

  // datapath next values
  always_comb begin
    kind_nxt = kind_r;
    an_nxt   = an_r;
    ad_nxt   = ad_r;
    bn_nxt   = bn_r;
    bd_nxt   = bd_r;
    p0_nxt   = p0_r;
    p1_nxt   = p1_r;
    p2_nxt   = p2_r;
    n_nxt    = n_r;
    d_nxt    = d_r;
    neg_nxt  = neg_r;
    mag_nxt  = mag_r;
    gx_nxt   = gx_r;
    gy_nxt   = gy_r;
    g_nxt    = g_r;
    k_nxt    = k_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    nq_nxt   = nq_r;
    dq_nxt   = dq_r;
    res_nxt  = res_r;
    take     = ~alu_sum[AW-1];
    q_step   = {q_r[PW-2:0], take};
    mag_v    = n_r[PW-1] ? alu_sum[PW-1:0] : n_r;
    fin_val  = neg_r ? alu_sum : {1'b0, nq_r};

    if (ctl.load) begin
      // low operand bits only; wide settings see the port zero extended
      kind_nxt = in_cmd.kind;
      an_nxt   = signed'(W'({{W{1'b0}}, in_cmd.a_num}));
      bn_nxt   = signed'(W'({{W{1'b0}}, in_cmd.b_num}));
      ad_nxt   = (W-1)'({{W{1'b0}}, in_cmd.a_den});
      bd_nxt   = (W-1)'({{W{1'b0}}, in_cmd.b_den});
      res_nxt  = '0;
    end

    case (ctl.st)
      ST_MUL0: p0_nxt = mul_p;
      ST_MUL1: p1_nxt = mul_p;
      ST_MUL2: p2_nxt = mul_p;
      ST_FORM: begin
        case (kind_r)
          KIND_ADD, KIND_SUB: begin
            n_nxt = signed'(alu_sum[PW-1:0]);
            d_nxt = p2_r;
          end
          KIND_MUL, KIND_DIV: begin
            n_nxt = p0_r;
            d_nxt = p1_r;
          end
          default: begin
            n_nxt = p0_r;
            d_nxt = p1_r;
          end
        endcase
        case (kind_r)
          KIND_EQ: res_nxt.cmp_true = (alu_sum == '0);
          KIND_GT: res_nxt.cmp_true = ~alu_sum[AW-1] && (alu_sum != '0);
          KIND_LT: res_nxt.cmp_true = alu_sum[AW-1];
          default: res_nxt.cmp_true = 1'b0;
        endcase
      end
      ST_SIGN: begin
        if (d_r == '0) begin
          res_nxt.div_error = 1'b1;
        end else begin
          // result sign kept apart, denominator made positive
          neg_nxt = n_r[PW-1] ^ d_r[PW-1];
          if (d_r[PW-1]) d_nxt = signed'(alu_sum[PW-1:0]);
        end
      end
      ST_MAG: begin
        mag_nxt = mag_v;
        k_nxt   = '0;
        if (mag_v == '0) begin
          // zero numerator reduces by one
          gx_nxt = PW'(1);
          gy_nxt = PW'(1);
        end else begin
          gx_nxt = mag_v;
          gy_nxt = d_r;
        end
      end
      ST_GCD: begin
        if (gx_zero || gy_zero) begin
          g_nxt = gx_zero ? gy_r : gx_r;
        end else if (!gx_r[0] && !gy_r[0]) begin
          gx_nxt = gx_r >> 1;
          gy_nxt = gy_r >> 1;
          k_nxt  = k_r + KW'(1);
        end else if (!gx_r[0]) begin
          gx_nxt = gx_r >> 1;
        end else if (!gy_r[0]) begin
          gy_nxt = gy_r >> 1;
        end else if (!alu_sum[AW-1]) begin
          gx_nxt = alu_sum[PW-1:0];
        end else begin
          // keep the larger value in gx
          gx_nxt = gy_r;
          gy_nxt = gx_r;
        end
      end
      ST_SHIFT: begin
        if (k_r == '0) begin
          q_nxt   = mag_r;
          rem_nxt = '0;
        end else begin
          g_nxt = g_r << 1;
          k_nxt = k_r - KW'(1);
        end
      end
      ST_DIVN, ST_DIVD: begin
        rem_nxt = take ? alu_sum[PW-1:0] : alu_a[PW-1:0];
        q_nxt   = q_step;
        if (ctl.div_last) begin
          if (ctl.st == ST_DIVN) begin
            nq_nxt  = q_step;
            q_nxt   = d_r;
            rem_nxt = '0;
          end else begin
            dq_nxt = q_step;
          end
        end
      end
      ST_FIN: begin
        res_nxt.res_num = 32'(signed'(fin_val));
        res_nxt.res_den = 30'(dq_r);
      end
      default: begin
        res_nxt = res_nxt;
      end
    endcase
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    an_r   <= an_nxt;
    ad_r   <= ad_nxt;
    bn_r   <= bn_nxt;
    bd_r   <= bd_nxt;
    p0_r   <= p0_nxt;
    p1_r   <= p1_nxt;
    p2_r   <= p2_nxt;
    n_r    <= n_nxt;
    d_r    <= d_nxt;
    neg_r  <= neg_nxt;
    mag_r  <= mag_nxt;
    gx_r   <= gx_nxt;
    gy_r   <= gy_nxt;
    g_r    <= g_nxt;
    k_r    <= k_nxt;
    q_r    <= q_nxt;
    rem_r  <= rem_nxt;
    nq_r   <= nq_nxt;
    dq_r   <= dq_nxt;
    res_r  <= res_nxt;
  end

endmodule
